FILE: rtl/core/scn_pkg.sv
// shared types, constants and codes of the sir contact network step block
`timescale 1ns / 1ps

package scn_pkg;

   // network size and derived widths
   localparam int NODES     = 1024;
   localparam int IDX_W     = $clog2(NODES);
   localparam int NODE_W    = 10;
   localparam int COUNT_W   = 11;
   localparam int PROB_BITS = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1024);

   // node state codes
   localparam logic [1:0] ST_SUS = 2'd0;
   localparam logic [1:0] ST_INF = 2'd1;
   localparam logic [1:0] ST_REC = 2'd2;

   // request codes
   localparam logic [1:0] REQ_CONTACT = 2'd0;
   localparam logic [1:0] REQ_RECOVER = 2'd1;
   localparam logic [1:0] REQ_SEED    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_INFECT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_RECOVER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_REINFECT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT    = 2'd3;

   // one write into the node state table
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [1:0]       data;
   } scn_wr_type;

   // transaction held in the work stage
   typedef struct packed {
      logic [1:0]           req;
      logic [IDX_W-1:0]     idx_a;
      logic [IDX_W-1:0]     idx_b;
      logic [PROB_BITS-1:0] rand_first;
      logic [PROB_BITS-1:0] rand_second;
   } scn_item_type;

   // probability registers
   typedef struct packed {
      logic [PROB_BITS-1:0] infect;
      logic [PROB_BITS-1:0] recover;
      logic [PROB_BITS-1:0] reinfect;
   } scn_prob_type;

   // outcome of one step
   typedef struct packed {
      scn_wr_type         wr;
      logic [1:0]         state_a;
      logic [1:0]         state_b;
      logic [COUNT_W-1:0] infected;
      logic [COUNT_W-1:0] recovered;
   } scn_step_type;

endpackage

FILE: rtl/core/scn_node_mem.sv
// node state table: two registered read ports, one write port, clearing sweep after reset
`timescale 1ns / 1ps

module scn_node_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [scn_pkg::IDX_W-1:0] rd_addr_a,
   input  logic [scn_pkg::IDX_W-1:0] rd_addr_b,
   output logic [1:0]              rd_a,
   output logic [1:0]              rd_b,
   input  scn_pkg::scn_wr_type     wr,
   output logic                    clearing
);

   logic [1:0]                mem [scn_pkg::NODES];
   logic                      clr_busy_ff;
   logic                      clr_busy_in;
   logic [scn_pkg::IDX_W-1:0] clr_addr_ff;
   logic [scn_pkg::IDX_W-1:0] clr_addr_in;
   logic                      wr_en;
   logic [scn_pkg::IDX_W-1:0] wr_addr;
   logic [1:0]                wr_data;
   logic [1:0]                rd_a_ff;
   logic [1:0]                rd_b_ff;

   // sweep control
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == scn_pkg::IDX_W'(scn_pkg::NODES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared between sweep and updates
   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = scn_pkg::ST_SUS;
      end else begin
         wr_en   = wr.en;
         wr_addr = wr.addr;
         wr_data = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_a     = rd_a_ff;
   assign rd_b     = rd_b_ff;
   assign clearing = clr_busy_ff;

endmodule

FILE: rtl/core/scn_step_logic.sv
// state transition of the two nodes and the population counters for one transaction
`timescale 1ns / 1ps

module scn_step_logic (
   input  scn_pkg::scn_item_type             item,
   input  logic [1:0]                        st_a,
   input  logic [1:0]                        st_b,
   input  scn_pkg::scn_prob_type             prob,
   input  logic [scn_pkg::COUNT_W-1:0]       infected,
   input  logic [scn_pkg::COUNT_W-1:0]       recovered,
   output scn_pkg::scn_step_type             step
);

   function automatic logic chance(input logic [scn_pkg::PROB_BITS-1:0] draw,
                                   input logic [scn_pkg::PROB_BITS-1:0] p);
      return draw < p;
   endfunction

   logic       same_node;
   logic       hit_fwd;
   logic       hit_rev;
   logic       hit_rec;
   logic [1:0] new_a;
   logic [1:0] new_b;
   logic       chg_a;
   logic       chg_b;
   logic       inf_up;
   logic       inf_down;
   logic       rec_up;
   logic       rec_down;

   assign same_node = (item.idx_a == item.idx_b);

   // probability tests, chosen by the target's current state
   assign hit_fwd = (st_b == scn_pkg::ST_SUS) ? chance(item.rand_first, prob.infect)
                                              : chance(item.rand_first, prob.reinfect);
   assign hit_rev = (st_a == scn_pkg::ST_SUS) ? chance(item.rand_second, prob.infect)
                                              : chance(item.rand_second, prob.reinfect);
   assign hit_rec = chance(item.rand_first, prob.recover);

   always_comb begin
      chg_a    = 1'b0;
      chg_b    = 1'b0;
      new_a    = st_a;
      new_b    = st_b;
      inf_up   = 1'b0;
      inf_down = 1'b0;
      rec_up   = 1'b0;
      rec_down = 1'b0;
      unique case (item.req)
         scn_pkg::REQ_CONTACT: begin
            // a self contact never changes anything
            if (!same_node) begin
               if (st_a == scn_pkg::ST_INF && st_b != scn_pkg::ST_INF && hit_fwd) begin
                  chg_b    = 1'b1;
                  new_b    = scn_pkg::ST_INF;
                  inf_up   = 1'b1;
                  rec_down = (st_b == scn_pkg::ST_REC);
               end else if (st_b == scn_pkg::ST_INF && st_a != scn_pkg::ST_INF && hit_rev) begin
                  chg_a    = 1'b1;
                  new_a    = scn_pkg::ST_INF;
                  inf_up   = 1'b1;
                  rec_down = (st_a == scn_pkg::ST_REC);
               end
            end
         end
         scn_pkg::REQ_RECOVER: begin
            if (st_a == scn_pkg::ST_INF && hit_rec) begin
               chg_a    = 1'b1;
               new_a    = scn_pkg::ST_REC;
               inf_down = 1'b1;
               rec_up   = 1'b1;
            end
         end
         scn_pkg::REQ_SEED: begin
            if (st_a != scn_pkg::ST_INF) begin
               chg_a    = 1'b1;
               new_a    = scn_pkg::ST_INF;
               inf_up   = 1'b1;
               rec_down = (st_a == scn_pkg::ST_REC);
            end
         end
         default: begin
         end
      endcase
      // node b reads back the update when both indexes name one node
      if (same_node && chg_a) begin
         new_b = new_a;
      end
   end

   // at most one node changes per transaction
   assign step.wr.en    = chg_a | chg_b;
   assign step.wr.addr  = chg_a ? item.idx_a : item.idx_b;
   assign step.wr.data  = chg_a ? new_a : new_b;
   assign step.state_a  = new_a;
   assign step.state_b  = new_b;
   assign step.infected = infected + scn_pkg::COUNT_W'(inf_up)
                          - scn_pkg::COUNT_W'(inf_down);
   assign step.recovered = recovered + scn_pkg::COUNT_W'(rec_up)
                           - scn_pkg::COUNT_W'(rec_down);

endmodule

FILE: rtl/core/sir_contact_network_step.sv
// top level of the sir contact network step block
`timescale 1ns / 1ps

// Keeps a 1024-entry table of node states (susceptible, infected, recovered)
// plus infected and recovered counters, and answers each request transaction
// (contact, recovery check, seed) with both node states and the three counts.
// One transaction is taken per clock while req_stall is low: the node table
// is read when the transaction is accepted, the update is computed and
// written back when the work stage passes it on, and the result lands in
// an output register; a one-entry bypass of the last write keeps
// back-to-back transactions on the same node correct. After reset the
// table is cleared by a sweep over all 1024 entries, one entry a cycle,
// during which req_stall stays high; register writes are taken throughout.
module sir_contact_network_step (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [scn_pkg::NODE_W-1:0]         req_node_a,
   input  logic [scn_pkg::NODE_W-1:0]         req_node_b,
   input  logic [scn_pkg::PROB_BITS-1:0]      req_rand_first,
   input  logic [scn_pkg::PROB_BITS-1:0]      req_rand_second,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_state_a,
   output logic [1:0]                         rsp_state_b,
   output logic [scn_pkg::COUNT_W-1:0]        rsp_count_susceptible,
   output logic [scn_pkg::COUNT_W-1:0]        rsp_count_infected,
   output logic [scn_pkg::COUNT_W-1:0]        rsp_count_recovered,
   // register write port
   input  logic                               csr_write,
   input  logic [scn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scn_pkg::CSR_W-1:0]          csr_wdata
);

   scn_pkg::scn_prob_type              prob_ff;
   logic [scn_pkg::COUNT_W-1:0]        node_count_ff;

   scn_pkg::scn_item_type              item_ff;
   scn_pkg::scn_item_type              item_in;
   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic                               s1_fire;
   logic                               req_take;

   logic [scn_pkg::COUNT_W-1:0]        infected_ff;
   logic [scn_pkg::COUNT_W-1:0]        recovered_ff;

   scn_pkg::scn_wr_type                last_wr_ff;
   logic                               clearing;
   logic [1:0]                         rd_a;
   logic [1:0]                         rd_b;
   logic [1:0]                         st_a;
   logic [1:0]                         st_b;
   scn_pkg::scn_step_type              step;
   scn_pkg::scn_wr_type                mem_wr;

   logic [scn_pkg::COUNT_W:0]          used;
   logic [scn_pkg::COUNT_W-1:0]        sus;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [1:0]                         state_a_ff;
   logic [1:0]                         state_b_ff;
   logic [scn_pkg::COUNT_W-1:0]        sus_ff;
   logic [scn_pkg::COUNT_W-1:0]        inf_out_ff;
   logic [scn_pkg::COUNT_W-1:0]        rec_out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prob_ff       <= '0;
         node_count_ff <= scn_pkg::NODE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            scn_pkg::CSR_PROB_INFECT:   prob_ff.infect   <= csr_wdata;
            scn_pkg::CSR_PROB_RECOVER:  prob_ff.recover  <= csr_wdata;
            scn_pkg::CSR_PROB_REINFECT: prob_ff.reinfect <= csr_wdata;
            scn_pkg::CSR_NODE_COUNT:    node_count_ff    <= csr_wdata[scn_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake of the work stage
   assign s1_fire      = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = clearing | (s1_valid_ff & ~s1_fire);
   assign req_take     = req_valid & ~req_stall;
   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_fire);
   assign rsp_valid_in = s1_fire | (rsp_valid_ff & rsp_stall);

   always_comb begin
      item_in.req         = req_type;
      item_in.idx_a       = req_node_a[scn_pkg::IDX_W-1:0];
      item_in.idx_b       = req_node_b[scn_pkg::IDX_W-1:0];
      item_in.rand_first  = req_rand_first;
      item_in.rand_second = req_rand_second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // node table, read on acceptance
   scn_node_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_addr_a (item_in.idx_a),
      .rd_addr_b (item_in.idx_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .wr        (mem_wr),
      .clearing  (clearing)
   );

   // bypass of the write made by the previous transaction
   assign st_a = (last_wr_ff.en && last_wr_ff.addr == item_ff.idx_a) ? last_wr_ff.data : rd_a;
   assign st_b = (last_wr_ff.en && last_wr_ff.addr == item_ff.idx_b) ? last_wr_ff.data : rd_b;

   scn_step_logic u_step (
      .item      (item_ff),
      .st_a      (st_a),
      .st_b      (st_b),
      .prob      (prob_ff),
      .infected  (infected_ff),
      .recovered (recovered_ff),
      .step      (step)
   );

   always_comb begin
      mem_wr    = step.wr;
      mem_wr.en = step.wr.en & s1_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_ff   <= '0;
         infected_ff  <= '0;
         recovered_ff <= '0;
      end else if (s1_fire) begin
         last_wr_ff   <= step.wr;
         infected_ff  <= step.infected;
         recovered_ff <= step.recovered;
      end
   end

   // susceptible count, saturated at zero
   assign used = {1'b0, step.infected} + {1'b0, step.recovered};
   assign sus  = ({1'b0, node_count_ff} > used)
                 ? scn_pkg::COUNT_W'({1'b0, node_count_ff} - used) : '0;

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         state_a_ff <= step.state_a;
         state_b_ff <= step.state_b;
         sus_ff     <= sus;
         inf_out_ff <= step.infected;
         rec_out_ff <= step.recovered;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_state_a           = state_a_ff;
   assign rsp_state_b           = state_b_ff;
   assign rsp_count_susceptible = sus_ff;
   assign rsp_count_infected    = inf_out_ff;
   assign rsp_count_recovered   = rec_out_ff;

   // the population never outgrows the table
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, infected_ff} + {1'b0, recovered_ff}) <= (scn_pkg::COUNT_W + 1)'(scn_pkg::NODES))
      else $error("infected plus recovered exceeds node count");

   // no transaction enters the work stage while the table is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !s1_fire)
      else $error("transaction processed during table clear");

   // counters move only when a transaction completes
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(infected_ff) && $stable(recovered_ff))
      else $error("counter changed without a transaction");

   // a completed transaction is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("completed transaction lost");

   // a transaction that changes no node leaves the infected count unchanged
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !step.wr.en) |=> $stable(infected_ff))
      else $error("infected count moved with no node change");

endmodule
